// ----- rtl/core/wswr_pkg.sv -----
// ----------------------------------------------------------------------------
// wswr_pkg
// Shared types and constants for the weighted sampler without replacement.
// ----------------------------------------------------------------------------
package wswr_pkg;

  localparam int W_WEIGHT = 32;
  localparam int W_PARTY  = 16;
  localparam int W_PICK   = 7;
  localparam int W_SUM    = 38;

  localparam logic [W_SUM-1:0] SUM_MAX = {W_SUM{1'b1}};

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_MAX_PICKS   = 64;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_DRAW  = 2'd2
  } wswr_mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } wswr_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STATUS,
    S_ALL_RD,
    S_ALL_WR,
    S_WALK,
    S_HIT
  } wswr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load;
    logic         start;
    logic         arm;
    logic         draw_begin;
    logic         set_status;
    wswr_status_t status_code;
    logic         status_emit;
    logic         walk;
    logic         all_rd;
    logic         all_emit;
    logic         hit_emit;
  } wswr_cmd_t;

  // Flags from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic n_zero;
    logic n_ge_cnt;
    logic draw_bad_arm;
    logic draw_ge_rem;
    logic walk_hit;
    logic walk_done;
    logic all_last;
    logic out_free;
  } wswr_sts_t;

endpackage

// ----- rtl/core/wswr_ctrl.sv -----
// ----------------------------------------------------------------------------
// wswr_ctrl
// Controller: decodes accepted beats and sequences table walks and results.
// ----------------------------------------------------------------------------
module wswr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic [1:0]           in_mode,
  input  wswr_pkg::wswr_sts_t  sts,
  output logic                 in_tready,
  output wswr_pkg::wswr_cmd_t  cmd
);
  import wswr_pkg::*;

  wswr_state_t state_r, state_nxt;
  logic        accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (wswr_mode_t'(in_mode))
            MODE_LOAD: begin
              if (sts.full) state_nxt = S_STATUS;
            end
            MODE_START: begin
              if (sts.cnt_zero) begin
                state_nxt = S_STATUS;
              end else if (!sts.n_zero && sts.n_ge_cnt) begin
                state_nxt = S_ALL_RD;
              end
            end
            MODE_DRAW: begin
              if (sts.draw_bad_arm || sts.draw_ge_rem) begin
                state_nxt = S_STATUS;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_STATUS: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_ALL_RD: state_nxt = S_ALL_WR;
      S_ALL_WR: begin
        if (sts.out_free) state_nxt = sts.all_last ? S_IDLE : S_ALL_RD;
      end
      S_WALK: begin
        if (sts.walk_hit) begin
          state_nxt = S_HIT;
        end else if (sts.walk_done) begin
          state_nxt = S_STATUS;
        end
      end
      S_HIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status_code = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (wswr_mode_t'(in_mode))
            MODE_LOAD: begin
              cmd.load = 1'b1;
              if (sts.full) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_FULL;
              end
            end
            MODE_START: begin
              cmd.start = 1'b1;
              if (sts.cnt_zero) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_EMPTY;
              end else if (!sts.n_zero && !sts.n_ge_cnt) begin
                cmd.arm = 1'b1;
              end
            end
            MODE_DRAW: begin
              if (sts.draw_bad_arm) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_EMPTY;
              end else if (sts.draw_ge_rem) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_RANGE;
              end else begin
                cmd.draw_begin = 1'b1;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      S_STATUS: cmd.status_emit = sts.out_free;
      S_ALL_RD: cmd.all_rd = 1'b1;
      S_ALL_WR: cmd.all_emit = sts.out_free;
      S_WALK: begin
        cmd.walk = 1'b1;
        // A walk that runs off the end without a hit reports out of range.
        if (!sts.walk_hit && sts.walk_done) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_RANGE;
        end
      end
      S_HIT: cmd.hit_emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/wswr_dp.sv -----
// ----------------------------------------------------------------------------
// wswr_dp
// Datapath: entry memories, removal marks, weight sums, walk pipeline and
// the output register.
// ----------------------------------------------------------------------------
module wswr_dp #(
  parameter int MAX_ENTRIES = wswr_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_PICKS   = wswr_pkg::DEF_MAX_PICKS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_first,
  input  logic [wswr_pkg::W_WEIGHT-1:0]  in_weight,
  input  logic [wswr_pkg::W_PARTY-1:0]   in_party,
  input  logic [wswr_pkg::W_PICK-1:0]    in_pick,
  input  logic [wswr_pkg::W_SUM-1:0]     in_draw,
  input  wswr_pkg::wswr_cmd_t            cmd,
  output wswr_pkg::wswr_sts_t            sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wswr_pkg::W_PARTY-1:0]   out_party,
  output logic                           out_last,
  output logic [1:0]                     out_status
);
  import wswr_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > W_PICK) ? CNT_W : W_PICK;
  localparam int AW    = (W_WEIGHT + CNT_W > W_SUM) ? W_WEIGHT + CNT_W : W_SUM;

  logic [W_WEIGHT-1:0] weight_mem [MAX_ENTRIES];
  logic [W_PARTY-1:0]  party_mem  [MAX_ENTRIES];

  logic [CNT_W-1:0]       count_r;
  logic [W_SUM-1:0]       total_r, rem_r, draw_r;
  logic [W_PICK-1:0]      picks_r, npick_r, all_idx_r;
  logic                   armed_r;
  logic [MAX_ENTRIES-1:0] marks_r;
  logic [CNT_W-1:0]       issue_r;
  logic [IDX_W-1:0]       eval_idx_r, hit_idx_r;
  logic                   pv_r;
  logic [AW-1:0]          acc_r;
  logic [W_WEIGHT-1:0]    rd_w_r, hit_w_r;
  logic [W_PARTY-1:0]     rd_p_r, hit_p_r;
  wswr_status_t           code_r;
  logic                   out_valid_r, out_last_r;
  logic [W_PARTY-1:0]     out_party_r;
  logic [1:0]             out_status_r;

  logic [W_PICK-1:0]      n_sat, picks_dec;
  logic                   full, issue_ok, w_live, rd_en, any_emit;
  logic [AW-1:0]          acc_sum;
  logic [IDX_W-1:0]       rd_addr, all_addr, wr_addr;
  logic [CNT_W-1:0]       base_cnt;
  logic [W_SUM-1:0]       base_total, base_rem;
  logic [W_SUM:0]         total_add, rem_add;

  assign n_sat     = (in_pick > W_PICK'(MAX_PICKS)) ? W_PICK'(MAX_PICKS) : in_pick;
  assign full      = !in_first && (count_r == CNT_W'(MAX_ENTRIES));
  assign issue_ok  = (issue_r < count_r);
  assign w_live    = pv_r && !marks_r[eval_idx_r];
  assign acc_sum   = acc_r + AW'(rd_w_r);
  assign picks_dec = (picks_r == '0) ? '0 : picks_r - 1'b1;

  // Past the loaded entries the emit-all sequence pads with entry zero.
  assign all_addr = (CMP_W'(all_idx_r) < CMP_W'(count_r)) ?
                    IDX_W'(all_idx_r) : '0;
  assign rd_addr  = cmd.all_rd ? all_addr : issue_r[IDX_W-1:0];
  assign rd_en    = cmd.all_rd || (cmd.walk && issue_ok);

  assign base_cnt   = in_first ? '0 : count_r;
  assign base_total = in_first ? '0 : total_r;
  assign base_rem   = in_first ? '0 : rem_r;
  assign wr_addr    = base_cnt[IDX_W-1:0];
  assign total_add  = {1'b0, base_total} + (W_SUM + 1)'(in_weight);
  assign rem_add    = {1'b0, base_rem} + (W_SUM + 1)'(in_weight);

  assign any_emit = cmd.status_emit || cmd.all_emit || cmd.hit_emit;

  always_comb begin
    sts              = '0;
    sts.full         = full;
    sts.cnt_zero     = (count_r == '0);
    sts.n_zero       = (n_sat == '0);
    sts.n_ge_cnt     = (CMP_W'(n_sat) >= CMP_W'(count_r));
    sts.draw_bad_arm = !armed_r || (rem_r == '0);
    sts.draw_ge_rem  = (in_draw >= rem_r);
    sts.walk_hit     = w_live && (AW'(draw_r) < acc_sum);
    sts.walk_done    = !pv_r && !issue_ok;
    sts.all_last     = (W_PICK'(all_idx_r + 1'b1) == npick_r);
    sts.out_free     = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      weight_mem[wr_addr] <= in_weight;
      party_mem[wr_addr]  <= in_party;
    end
    if (rd_en) begin
      rd_w_r <= weight_mem[rd_addr];
      rd_p_r <= party_mem[rd_addr];
    end
  end

  // Control state and sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      total_r     <= '0;
      rem_r       <= '0;
      picks_r     <= '0;
      armed_r     <= 1'b0;
      marks_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        armed_r <= 1'b0;
        picks_r <= '0;
        if (in_first) begin
          marks_r <= '0;
        end else if (!full) begin
          marks_r[wr_addr] <= 1'b0;
        end
        // A first entry is never full, so the base values already start over.
        if (!full) begin
          count_r <= base_cnt + 1'b1;
          total_r <= total_add[W_SUM] ? SUM_MAX : total_add[W_SUM-1:0];
          rem_r   <= rem_add[W_SUM] ? SUM_MAX : rem_add[W_SUM-1:0];
        end
      end
      if (cmd.start) begin
        marks_r <= '0;
        rem_r   <= total_r;
        armed_r <= cmd.arm;
        picks_r <= cmd.arm ? n_sat : '0;
      end
      if (cmd.draw_begin) begin
        pv_r <= 1'b0;
      end
      if (cmd.walk) begin
        pv_r <= issue_ok;
      end
      if (cmd.hit_emit) begin
        marks_r[hit_idx_r] <= 1'b1;
        rem_r   <= (W_SUM'(hit_w_r) > rem_r) ? '0 : rem_r - W_SUM'(hit_w_r);
        picks_r <= picks_dec;
        if (picks_dec == '0) armed_r <= 1'b0;
      end
      if (any_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk pipeline, sequence counters and result payload.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      npick_r   <= n_sat;
      all_idx_r <= '0;
    end
    if (cmd.draw_begin) begin
      draw_r  <= in_draw;
      issue_r <= '0;
      acc_r   <= '0;
    end
    if (cmd.set_status) begin
      code_r <= cmd.status_code;
    end
    if (cmd.walk) begin
      if (issue_ok) begin
        issue_r    <= issue_r + 1'b1;
        eval_idx_r <= issue_r[IDX_W-1:0];
      end
      if (w_live) acc_r <= acc_sum;
      if (sts.walk_hit) begin
        hit_idx_r <= eval_idx_r;
        hit_w_r   <= rd_w_r;
        hit_p_r   <= rd_p_r;
      end
    end
    if (cmd.status_emit) begin
      out_party_r  <= '0;
      out_last_r   <= 1'b0;
      out_status_r <= code_r;
    end
    if (cmd.all_emit) begin
      out_party_r  <= rd_p_r;
      out_last_r   <= sts.all_last;
      out_status_r <= ST_OK;
      all_idx_r    <= all_idx_r + 1'b1;
    end
    if (cmd.hit_emit) begin
      out_party_r  <= hit_p_r;
      out_last_r   <= (picks_dec == '0);
      out_status_r <= ST_OK;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_party  = out_party_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

// ----- rtl/core/weighted_sample_without_replacement.sv -----
// ----------------------------------------------------------------------------
// weighted_sample_without_replacement
// Weighted sampling without replacement over a loaded table of parties.
// ----------------------------------------------------------------------------
// Input beats carry a mode in in_tuser: load appends an entry (first_entry
// empties the table first), start sets the pick count, draw supplies one
// random value below the remaining weight. Result beats carry the picked
// party in out_tdata, the final pick of a session on out_tlast and a status
// code in out_tuser.
// A load gives no result unless the table is full.
// A start whose count covers the table emits every party in table order,
// padded with the first one; each result is read in S_ALL_RD and emitted in S_ALL_WR.
// A draw walks the table one entry per cycle through the weight memory's
// read port.
// One item is in work at a time; a result sits in the output register
// while the receiver stalls, and the next result waits for it to drain.
// Reset empties the table and disarms; the memories are not cleared.
// ----------------------------------------------------------------------------
module weighted_sample_without_replacement #(
  parameter int MAX_ENTRIES = wswr_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_PICKS   = wswr_pkg::DEF_MAX_PICKS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // first_entry[0], entry_weight_in[32:1], entry_party_in[48:33],
  // pick_count[55:49], draw_value[93:56], zero[95:94]
  input  logic [95:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // picked_party[15:0]
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  // status[1:0]
  output logic [1:0]  out_tuser
);
  import wswr_pkg::*;

  wswr_cmd_t cmd;
  wswr_sts_t sts;

  wswr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  wswr_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_PICKS   (MAX_PICKS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_first   (in_tdata[0]),
    .in_weight  (in_tdata[32:1]),
    .in_party   (in_tdata[48:33]),
    .in_pick    (in_tdata[55:49]),
    .in_draw    (in_tdata[93:56]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_party  (out_tdata),
    .out_last   (out_tlast),
    .out_status (out_tuser)
  );

endmodule
